>>> sv/bfp_pkg.sv
// Shared types, command codes and helpers for the bitstream field packer.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps

package bfp_pkg;

    // Default buffer size limit in words
    localparam int unsigned MAX_WORDS = 32768;

    localparam int unsigned POS_W   = 21;
    localparam int unsigned INDEX_W = 15;
    localparam int unsigned QDEPTH  = 2;

    // Input command codes
    localparam logic [2:0] CMD_UNSIGNED = 3'd0;
    localparam logic [2:0] CMD_SIGNED   = 3'd1;
    localparam logic [2:0] CMD_VARINT   = 3'd2;
    localparam logic [2:0] CMD_FLUSH    = 3'd3;
    localparam logic [2:0] CMD_RESTART  = 3'd4;

    // Decoded operations handed from the front to the back
    localparam logic [1:0] OP_NOP     = 2'd0;
    localparam logic [1:0] OP_WRITE   = 2'd1;
    localparam logic [1:0] OP_FLUSH   = 2'd2;
    localparam logic [1:0] OP_RESTART = 2'd3;

    // Configuration register index
    localparam logic REG_CAPACITY = 1'b0;

    // Varint prefixes
    localparam logic [1:0] VPFX_4  = 2'd0;
    localparam logic [1:0] VPFX_8  = 2'd1;
    localparam logic [1:0] VPFX_12 = 2'd2;
    localparam logic [1:0] VPFX_32 = 2'd3;

    // A write is one field of up to 34 bits whose first piece is the low
    // first_count bits; the remainder is only written when all of it fits.
    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] first_bits;
        logic [5:0]  first_count;
        logic [33:0] all_bits;
        logic [5:0]  all_count;
    } item_t;

    function automatic logic [31:0] low_mask(input logic [5:0] n);
        logic [31:0] m;
        if (n >= 6'd32)
        begin
            m = '1;
        end
        else
        begin
            m = (32'd1 << n) - 32'd1;
        end
        return m;
    endfunction

endpackage

>>> sv/bfp_front.sv
// Front end: accepts input transfers and decodes each command into one item.
// Depends on bfp_pkg.
`timescale 1ns / 1ps

module bfp_front (
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [2:0]      command,
    input  logic [31:0]     value,
    input  logic [5:0]      bit_count,
    input  logic            q_full,
    output logic            q_push,
    output bfp_pkg::item_t  q_item
);

    logic [5:0]  n_sat;
    logic [5:0]  n_less;
    logic [31:0] masked;
    logic [31:0] masked_less;
    logic [5:0]  vk;
    logic [1:0]  vpfx;

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        n_sat       = (bit_count > 6'd32) ? 6'd32 : bit_count;
        n_less      = (n_sat == 6'd0) ? 6'd0 : n_sat - 6'd1;
        masked      = value & bfp_pkg::low_mask(n_sat);
        masked_less = value & bfp_pkg::low_mask(n_less);

        // pick the smallest varint width that holds the value
        if (value <= 32'hf)
        begin
            vk   = 6'd4;
            vpfx = bfp_pkg::VPFX_4;
        end
        else if (value <= 32'hff)
        begin
            vk   = 6'd8;
            vpfx = bfp_pkg::VPFX_8;
        end
        else if (value <= 32'hfff)
        begin
            vk   = 6'd12;
            vpfx = bfp_pkg::VPFX_12;
        end
        else
        begin
            vk   = 6'd32;
            vpfx = bfp_pkg::VPFX_32;
        end

        q_item             = '0;
        q_item.op          = bfp_pkg::OP_NOP;
        unique case (command)
            bfp_pkg::CMD_UNSIGNED:
            begin
                q_item.op          = bfp_pkg::OP_WRITE;
                q_item.first_bits  = masked;
                q_item.first_count = n_sat;
                q_item.all_bits    = {2'b00, masked};
                q_item.all_count   = n_sat;
            end
            bfp_pkg::CMD_SIGNED:
            begin
                // low n-1 bits, then the sign bit on top
                q_item.op          = bfp_pkg::OP_WRITE;
                q_item.first_bits  = masked_less;
                q_item.first_count = n_less;
                q_item.all_bits    = (n_sat == 6'd0) ? 34'd0 :
                                     ({2'b00, masked_less} | ({33'd0, value[31]} << n_less));
                q_item.all_count   = n_sat;
            end
            bfp_pkg::CMD_VARINT:
            begin
                q_item.op          = bfp_pkg::OP_WRITE;
                q_item.first_bits  = {30'd0, vpfx};
                q_item.first_count = 6'd2;
                q_item.all_bits    = {value & bfp_pkg::low_mask(vk), vpfx};
                q_item.all_count   = vk + 6'd2;
            end
            bfp_pkg::CMD_FLUSH:
            begin
                q_item.op = bfp_pkg::OP_FLUSH;
            end
            bfp_pkg::CMD_RESTART:
            begin
                q_item.op = bfp_pkg::OP_RESTART;
            end
            default:
            begin
                q_item.op = bfp_pkg::OP_NOP;
            end
        endcase
    end

endmodule

>>> sv/bfp_queue.sv
// Two-entry queue of decoded items between the front and back ends.
// Depends on bfp_pkg.
`timescale 1ns / 1ps

module bfp_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  bfp_pkg::item_t  push_item,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output bfp_pkg::item_t  head_item
);

    localparam int unsigned CNT_W = $clog2(bfp_pkg::QDEPTH + 1);
    localparam int unsigned PTR_W = $clog2(bfp_pkg::QDEPTH);

    bfp_pkg::item_t entry_reg [bfp_pkg::QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(bfp_pkg::QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(bfp_pkg::QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(bfp_pkg::QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> sv/bfp_back.sv
// Back end: merges decoded items into the pending word, tracks position and
// overflow, and holds the result in an output register. Depends on bfp_pkg.
`timescale 1ns / 1ps

module bfp_back #(
    parameter int unsigned MAX_WORDS = bfp_pkg::MAX_WORDS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [bfp_pkg::POS_W-1:0]   capacity,
    input  logic                        head_valid,
    input  bfp_pkg::item_t              head_item,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  word_count,
    output logic [31:0]                 first_word,
    output logic [31:0]                 second_word,
    output logic [bfp_pkg::INDEX_W-1:0] first_word_index,
    output logic [bfp_pkg::POS_W-1:0]   bit_position,
    output logic                        overflowed
);

    localparam int unsigned POS_W = bfp_pkg::POS_W;
    localparam logic [31:0] LIMIT = 32'(MAX_WORDS) * 32'd32;

    logic [31:0]      pend_reg, pend_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             ovf_reg, ovf_next;

    logic                        out_valid_reg, out_valid_next;
    logic [1:0]                  word_count_reg, word_count_next;
    logic [31:0]                 first_word_reg, first_word_next;
    logic [31:0]                 second_word_reg, second_word_next;
    logic [bfp_pkg::INDEX_W-1:0] index_reg, index_next;

    logic [POS_W-1:0] cap_eff;
    logic [POS_W:0]   sum_first;
    logic [POS_W:0]   sum_all;
    logic             fit_first;
    logic             fit_all;
    logic [5:0]       wr_count;
    logic [33:0]      wr_bits;
    logic [4:0]       sh;
    logic [95:0]      merged;
    logic [6:0]       end_bit;
    logic [1:0]       cnt;
    logic [31:0]      pend_wr;
    logic [POS_W-1:0] pos_wr;

    assign pop = head_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        cap_eff   = ({{(32 - POS_W){1'b0}}, capacity} < LIMIT) ? capacity : LIMIT[POS_W-1:0];
        sum_first = {1'b0, pos_reg} + {{(POS_W - 5){1'b0}}, head_item.first_count};
        sum_all   = {1'b0, pos_reg} + {{(POS_W - 5){1'b0}}, head_item.all_count};
        fit_first = (head_item.first_count == 6'd0) || (sum_first <= {1'b0, cap_eff});
        fit_all   = (head_item.all_count == 6'd0) || (sum_all <= {1'b0, cap_eff});

        // write the whole field, only its first piece, or nothing
        if (fit_all)
        begin
            wr_count = head_item.all_count;
            wr_bits  = head_item.all_bits;
        end
        else if (fit_first)
        begin
            wr_count = head_item.first_count;
            wr_bits  = {2'b00, head_item.first_bits};
        end
        else
        begin
            wr_count = 6'd0;
            wr_bits  = 34'd0;
        end

        sh      = pos_reg[4:0];
        merged  = {64'd0, pend_reg} | ({62'd0, wr_bits} << sh);
        end_bit = {2'b00, sh} + {1'b0, wr_count};
        cnt     = end_bit[6:5];
        case (cnt)
            2'd0:    pend_wr = merged[31:0];
            2'd1:    pend_wr = merged[63:32];
            default: pend_wr = merged[95:64];
        endcase
        pos_wr = pos_reg + {{(POS_W - 6){1'b0}}, wr_count};

        pend_next        = pend_reg;
        pos_next         = pos_reg;
        ovf_next         = ovf_reg;
        word_count_next  = 2'd0;
        first_word_next  = 32'd0;
        second_word_next = 32'd0;
        index_next       = '0;

        unique case (head_item.op)
            bfp_pkg::OP_WRITE:
            begin
                word_count_next  = cnt;
                first_word_next  = (cnt != 2'd0) ? merged[31:0] : 32'd0;
                second_word_next = (cnt == 2'd2) ? merged[63:32] : 32'd0;
                index_next       = (cnt != 2'd0) ? pos_reg[bfp_pkg::INDEX_W+4:5] : '0;
                if (fit_all)
                begin
                    pend_next = pend_wr;
                    pos_next  = pos_wr;
                end
                else
                begin
                    // clamp to capacity; keep the word only if its index holds
                    ovf_next  = 1'b1;
                    pos_next  = cap_eff;
                    pend_next = (cap_eff[POS_W-1:5] == pos_wr[POS_W-1:5]) ? pend_wr : 32'd0;
                end
            end
            bfp_pkg::OP_FLUSH:
            begin
                if (pos_reg[4:0] != 5'd0)
                begin
                    word_count_next = 2'd1;
                    first_word_next = pend_reg;
                    index_next      = pos_reg[bfp_pkg::INDEX_W+4:5];
                end
            end
            bfp_pkg::OP_RESTART:
            begin
                pend_next = 32'd0;
                pos_next  = '0;
                ovf_next  = 1'b0;
            end
            default:
            begin
                pend_next = pend_reg;
            end
        endcase

        out_valid_next = pop ? 1'b1 : (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 32'd0;
            pos_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                pend_reg <= pend_next;
                pos_reg  <= pos_next;
                ovf_reg  <= ovf_next;
            end
        end
    end

    // result payload; hold while stalled
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            word_count_reg  <= word_count_next;
            first_word_reg  <= first_word_next;
            second_word_reg <= second_word_next;
            index_reg       <= index_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign word_count       = word_count_reg;
    assign first_word       = first_word_reg;
    assign second_word      = second_word_reg;
    assign first_word_index = index_reg;
    assign bit_position     = pos_reg;
    assign overflowed       = ovf_reg;

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        pop && head_item.op == bfp_pkg::OP_RESTART |=> pos_reg == '0 && !ovf_reg)
        else $error("restart did not clear position and overflow");

    a_ovf_from_write: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovf_reg) |-> $past(pop && head_item.op == bfp_pkg::OP_WRITE))
        else $error("overflow set by something other than a write");

    a_flush_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        pop && head_item.op == bfp_pkg::OP_FLUSH
        |=> pos_reg == $past(pos_reg) && pend_reg == $past(pend_reg))
        else $error("flush changed the packer state");

    a_empty_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && word_count_reg == 2'd0
        |-> first_word_reg == 32'd0 && second_word_reg == 32'd0 && index_reg == '0)
        else $error("result with no words carries word data");

endmodule

>>> sv/bitstream_field_packer.sv
// Top level of the bitstream field packer: APB capacity register and the
// front end, item queue and back end. Depends on bfp_pkg, bfp_front,
// bfp_queue and bfp_back.
//
// Usage:
//   Input channel (in_valid / in_stall) takes one command per transfer:
//   unsigned, signed or varint field writes, flush or restart. Output channel
//   (out_valid / out_stall) returns exactly one result per command: up to two
//   completed 32-bit words with the index of the first, the bit position and
//   the sticky overflow flag after the command.
//   Each command is written into the queue, and its result is registered in
//   the output register. Throughput is one command per cycle while the
//   output is not stalled; the back end merges a whole field (up to 34 bits
//   including a varint prefix) into the pending word combinationally.
//   A two-entry queue sits between decode and merge, so a stalled output
//   holds its result while the queue fills; in_stall rises once the queue is
//   full. Reset clears the pending word, position, overflow flag, queue and
//   capacity (capacity zero makes every non-empty write overflow). Write the
//   capacity register at byte address 0 only while no command is in flight.
`timescale 1ns / 1ps

module bitstream_field_packer #(
    parameter int unsigned MAX_WORDS = bfp_pkg::MAX_WORDS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [2:0]                  command,
    input  logic [31:0]                 value,
    input  logic [5:0]                  bit_count,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  word_count,
    output logic [31:0]                 first_word,
    output logic [31:0]                 second_word,
    output logic [bfp_pkg::INDEX_W-1:0] first_word_index,
    output logic [bfp_pkg::POS_W-1:0]   bit_position,
    output logic                        overflowed
);

    localparam int unsigned POS_W = bfp_pkg::POS_W;

    logic [POS_W-1:0] capacity_reg, capacity_next;
    logic             cfg_write;
    logic             q_push;
    logic             q_full;
    logic             q_pop;
    logic             q_head_valid;
    bfp_pkg::item_t   q_push_item;
    bfp_pkg::item_t   q_head_item;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        capacity_next = capacity_reg;
        if (cfg_write && paddr[2] == bfp_pkg::REG_CAPACITY)
        begin
            capacity_next = pwdata[POS_W-1:0];
        end
        prdata = (paddr[2] == bfp_pkg::REG_CAPACITY) ?
                 {{(32 - POS_W){1'b0}}, capacity_reg} : 32'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= '0;
        end
        else
        begin
            capacity_reg <= capacity_next;
        end
    end

    bfp_front u_front (
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .value     (value),
        .bit_count (bit_count),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (q_push_item)
    );

    bfp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (q_push_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_item  (q_head_item)
    );

    bfp_back #(
        .MAX_WORDS (MAX_WORDS)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .capacity         (capacity_reg),
        .head_valid       (q_head_valid),
        .head_item        (q_head_item),
        .pop              (q_pop),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .word_count       (word_count),
        .first_word       (first_word),
        .second_word      (second_word),
        .first_word_index (first_word_index),
        .bit_position     (bit_position),
        .overflowed       (overflowed)
    );

endmodule
